FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted (active low).
`define GBEQ_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
		else $error("gbeq check failed");

// Clocked property that also holds during reset.
`define GBEQ_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error("gbeq check failed");

`endif

FILE: rtl/gbeq_pkg.sv
// Package with widths, register map, tracker map and shared types of the qualifier.
package gbeq_pkg;

	// Field widths
	localparam int TIME_W   = 32;
	localparam int WIN_W    = 16;
	localparam int LEVEL_W  = 15;
	localparam int TRIG_W   = 16;
	localparam int BTN_W    = 14;
	localparam int MASK_W   = 16;
	localparam int MODE_W   = 3;
	localparam int STEP_W   = 2;

	// Stream payload widths
	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 56;

	// Configuration port
	localparam int ADDR_W = 4;
	localparam logic [ADDR_W-1:0] ADDR_DEBOUNCE = 4'h0;
	localparam logic [ADDR_W-1:0] ADDR_DCLICK   = 4'h4;
	localparam logic [ADDR_W-1:0] ADDR_TRIGGER  = 4'h8;

	localparam logic [WIN_W-1:0]   DEBOUNCE_RESET = 16'd20;
	localparam logic [WIN_W-1:0]   DCLICK_RESET   = 16'd300;
	localparam logic [LEVEL_W-1:0] TRIGGER_RESET  = 15'd8000;

	// Tracker map
	localparam int NUM_TRACKERS = 20;
	localparam int NUM_STEPPERS = 6;
	localparam int TK_VOICE0 = 0;
	localparam int TK_L3     = 4;
	localparam int TK_A      = 5;
	localparam int TK_B      = 6;
	localparam int TK_X      = 7;
	localparam int TK_Y      = 8;
	localparam int TK_R3     = 9;
	localparam int TK_START  = 10;
	localparam int TK_GUIDE  = 11;
	localparam int TK_DPAD0  = 12;
	localparam int TK_M1_B   = 16;
	localparam int TK_M1_Y   = 17;
	localparam int TK_M1_X   = 18;
	localparam int TK_M1_A   = 19;

	// Option modes
	localparam logic [MODE_W-1:0] MODE_ZERO = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ONE  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_TWO  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_LAST = 3'd4;

	// Step codes
	localparam logic [STEP_W-1:0] STEP_NONE   = 2'b00;
	localparam logic [STEP_W-1:0] STEP_PLUS   = 2'b01;
	localparam logic [STEP_W-1:0] STEP_DOUBLE = 2'b10;

	// Status of one tracker after the current tick
	typedef struct packed {
		logic rise;   // accepted rising edge
		logic level;  // debounced level after update
	} trk_status_t;

endpackage

FILE: rtl/gamepad_button_event_qualifier_core.sv
// Top level of the gamepad button event qualifier: stream ports, config registers, datapath.
//
// Usage:
//  One poll tick enters per transfer on the s_axis channel; tdata carries the timestamp,
//  the present flag, 14 raw buttons and both trigger levels. Each tick yields exactly one
//  result on the m_axis channel: held mask, event pulses, mode, link state and six step
//  deltas. Thresholds and windows sit in three APB registers (0x0 debounce window,
//  0x4 double-click window, 0x8 trigger level); write them only while no tick is pending.
//  A tick is captured into the input register, evaluated against the tracker state in
//  one pass, and its result is held in the result register, which drives m_axis.
//  Throughput: one tick per cycle while m_axis_tready is high. Input and result
//  registers form a two-entry pipeline, so a new tick is taken while a finished result waits.
//  The per-cycle work is bounded by the dependency chain guide tracker, link, start
//  tracker, mode, then d-pad and face trackers, all in one combinational pass.
//  Reset clears all tracker levels and timestamps, the stepper press times, the mode,
//  the link and the present history, and loads the register defaults (20, 300, 8000).
//  When the receiver stalls, the result is held and the pipeline fills; s_axis_tready
//  drops once both stages are occupied.
module gamepad_button_event_qualifier_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Input ticks
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// [31:0] tick_time_ms, [32] pad_present, [46:33] button_levels,
	// [62:47] left_trigger_level, [78:63] right_trigger_level, [79] zero
	input  logic [gbeq_pkg::IN_DATA_W-1:0]       s_axis_tdata,
	// Results
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// [15:0] held_mask, [31:16] event_pulses, [34:32] mode_now, [35] link_active,
	// [36] link_changed, [38:37] dpad_up_step, [40:39] dpad_down_step,
	// [42:41] dpad_left_step, [44:43] dpad_right_step, [46:45] rate_step,
	// [48:47] order_step, [55:49] zero
	output logic [gbeq_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	// Configuration
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [gbeq_pkg::ADDR_W-1:0]          paddr,
	input  logic [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready
);

	// Configuration registers
	logic [gbeq_pkg::WIN_W-1:0]   debounce_q;
	logic [gbeq_pkg::WIN_W-1:0]   dclick_q;
	logic [gbeq_pkg::LEVEL_W-1:0] trigger_q;
	logic                         cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= gbeq_pkg::DEBOUNCE_RESET;
			dclick_q   <= gbeq_pkg::DCLICK_RESET;
			trigger_q  <= gbeq_pkg::TRIGGER_RESET;
		end else if (cfg_wr) begin
			if (paddr == gbeq_pkg::ADDR_DEBOUNCE) debounce_q <= pwdata[gbeq_pkg::WIN_W-1:0];
			if (paddr == gbeq_pkg::ADDR_DCLICK)   dclick_q   <= pwdata[gbeq_pkg::WIN_W-1:0];
			if (paddr == gbeq_pkg::ADDR_TRIGGER)  trigger_q  <= pwdata[gbeq_pkg::LEVEL_W-1:0];
		end
	end

	// Register readback
	always_comb begin
		prdata = '0;
		if (paddr == gbeq_pkg::ADDR_DEBOUNCE) begin
			prdata = {16'b0, debounce_q};
		end else if (paddr == gbeq_pkg::ADDR_DCLICK) begin
			prdata = {16'b0, dclick_q};
		end else if (paddr == gbeq_pkg::ADDR_TRIGGER) begin
			prdata = {17'b0, trigger_q};
		end
	end

	// Pipeline control: input register and result register
	logic                              valid_s1;
	logic [gbeq_pkg::IN_DATA_W-1:0]    data_s1;
	logic                              out_valid_q;
	logic [gbeq_pkg::OUT_DATA_W-1:0]   out_data_q;
	logic                              advance;
	logic                              in_xfer;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) data_s1 <= s_axis_tdata;
	end

	// Unpack the tick
	logic [gbeq_pkg::TIME_W-1:0]        now;
	logic                               present;
	logic [gbeq_pkg::BTN_W-1:0]         btn;
	logic signed [gbeq_pkg::TRIG_W-1:0] trig_l;
	logic signed [gbeq_pkg::TRIG_W-1:0] trig_r;
	logic signed [gbeq_pkg::TRIG_W-1:0] trig_thr;
	logic                               trig_l_on;
	logic                               trig_r_on;

	assign now      = data_s1[31:0];
	assign present  = data_s1[32];
	assign btn      = data_s1[46:33];
	assign trig_l   = data_s1[62:47];
	assign trig_r   = data_s1[78:63];
	assign trig_thr = {1'b0, trigger_q};
	assign trig_l_on = trig_l > trig_thr;
	assign trig_r_on = trig_r > trig_thr;

	// Block state
	logic [gbeq_pkg::MODE_W-1:0] mode_q;
	logic                        link_q;
	logic                        was_present_q;

	// Trackers
	logic [gbeq_pkg::NUM_TRACKERS-1:0] trk_cur;
	logic [gbeq_pkg::NUM_TRACKERS-1:0] trk_en;
	logic [gbeq_pkg::NUM_TRACKERS-1:0] trk_rise;
	logic [gbeq_pkg::NUM_TRACKERS-1:0] trk_lvl;
	gbeq_pkg::trk_status_t             trk_status [gbeq_pkg::NUM_TRACKERS];

	// Raw level feeding each tracker
	always_comb begin
		trk_cur = '0;
		trk_cur[gbeq_pkg::TK_VOICE0]     = btn[0];
		trk_cur[gbeq_pkg::TK_VOICE0 + 1] = trig_l_on;
		trk_cur[gbeq_pkg::TK_VOICE0 + 2] = btn[1];
		trk_cur[gbeq_pkg::TK_VOICE0 + 3] = trig_r_on;
		trk_cur[gbeq_pkg::TK_L3]         = btn[2];
		trk_cur[gbeq_pkg::TK_A]          = btn[4];
		trk_cur[gbeq_pkg::TK_B]          = btn[5];
		trk_cur[gbeq_pkg::TK_X]          = btn[6];
		trk_cur[gbeq_pkg::TK_Y]          = btn[7];
		trk_cur[gbeq_pkg::TK_R3]         = btn[3];
		trk_cur[gbeq_pkg::TK_START]      = btn[8];
		trk_cur[gbeq_pkg::TK_GUIDE]      = btn[9];
		trk_cur[gbeq_pkg::TK_DPAD0 + 3:gbeq_pkg::TK_DPAD0] = btn[13:10];
		trk_cur[gbeq_pkg::TK_M1_B]       = btn[5];
		trk_cur[gbeq_pkg::TK_M1_Y]       = btn[7];
		trk_cur[gbeq_pkg::TK_M1_X]       = btn[6];
		trk_cur[gbeq_pkg::TK_M1_A]       = btn[4];
	end

	for (genvar gi = 0; gi < gbeq_pkg::NUM_TRACKERS; gi++) begin : g_trk
		gbeq_tracker u_trk (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (trk_en[gi]),
			.cur    (trk_cur[gi]),
			.now    (now),
			.window (debounce_q),
			.status (trk_status[gi])
		);
		assign trk_rise[gi] = trk_status[gi].rise;
		assign trk_lvl[gi]  = trk_status[gi].level;
	end

	// Link, mode and enables for this tick
	logic                        link_att;
	logic                        link_new;
	logic                        active;
	logic                        start_rise;
	logic [gbeq_pkg::MODE_W-1:0] mode_new;
	logic                        stepping;
	logic                        dpad_en;
	logic                        m1_en;

	always_comb begin
		link_att = link_q;
		if (present && !was_present_q) link_att = 1'b1;
		if (!present && was_present_q) link_att = 1'b0;
		link_new = trk_rise[gbeq_pkg::TK_GUIDE] ? !link_att : link_att;
		active   = present && link_new;

		start_rise = trk_rise[gbeq_pkg::TK_START];
		if (start_rise) begin
			mode_new = (mode_q == gbeq_pkg::MODE_LAST) ? gbeq_pkg::MODE_ZERO
				: mode_q + 3'd1;
		end else begin
			mode_new = mode_q;
		end
		stepping = (mode_new == gbeq_pkg::MODE_ONE) || (mode_new == gbeq_pkg::MODE_TWO);
		dpad_en  = active && !start_rise;
		m1_en    = dpad_en && (mode_new == gbeq_pkg::MODE_ONE);

		trk_en = '0;
		trk_en[gbeq_pkg::TK_R3:gbeq_pkg::TK_VOICE0] = {10{advance && active}};
		trk_en[gbeq_pkg::TK_START] = advance && active;
		trk_en[gbeq_pkg::TK_GUIDE] = advance && present;
		trk_en[gbeq_pkg::TK_DPAD0 + 3:gbeq_pkg::TK_DPAD0] = {4{advance && dpad_en}};
		trk_en[gbeq_pkg::TK_M1_A:gbeq_pkg::TK_M1_B] = {4{advance && m1_en}};
	end

	// Steppers: four d-pad directions, then triangle and square
	logic [gbeq_pkg::NUM_STEPPERS-1:0] step_press;
	logic [gbeq_pkg::STEP_W-1:0]       step_code [gbeq_pkg::NUM_STEPPERS];

	always_comb begin
		step_press[3:0] = trk_rise[gbeq_pkg::TK_DPAD0 + 3:gbeq_pkg::TK_DPAD0] & {4{stepping}};
		step_press[4]   = trk_rise[gbeq_pkg::TK_M1_Y];
		step_press[5]   = trk_rise[gbeq_pkg::TK_M1_X];
	end

	for (genvar gs = 0; gs < gbeq_pkg::NUM_STEPPERS; gs++) begin : g_step
		gbeq_stepper u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.press  (step_press[gs]),
			.now    (now),
			.window (dclick_q),
			.step   (step_code[gs])
		);
	end

	// Result assembly
	logic [gbeq_pkg::MASK_W-1:0]     held;
	logic [gbeq_pkg::MASK_W-1:0]     pulses;
	logic [gbeq_pkg::OUT_DATA_W-1:0] result;

	always_comb begin
		held   = '0;
		pulses = '0;
		if (active) begin
			held[3:0] = trk_lvl[gbeq_pkg::TK_VOICE0 + 3:gbeq_pkg::TK_VOICE0];
			held[4]   = trk_lvl[gbeq_pkg::TK_L3];
			held[5]   = trk_lvl[gbeq_pkg::TK_R3];
			held[6]   = trk_lvl[gbeq_pkg::TK_A];
			held[7]   = trk_lvl[gbeq_pkg::TK_X];
			held[8]   = trk_lvl[gbeq_pkg::TK_Y];
			held[9]   = trk_lvl[gbeq_pkg::TK_B];
			held[13:10] = trk_lvl[gbeq_pkg::TK_DPAD0 + 3:gbeq_pkg::TK_DPAD0];
			held[14]  = trk_lvl[gbeq_pkg::TK_START];
			held[15]  = trk_lvl[gbeq_pkg::TK_GUIDE];

			pulses[9:0]   = trk_rise[gbeq_pkg::TK_R3:gbeq_pkg::TK_VOICE0];
			pulses[13:10] = trk_rise[gbeq_pkg::TK_DPAD0 + 3:gbeq_pkg::TK_DPAD0]
				& {4{!stepping}};
			pulses[14]    = trk_rise[gbeq_pkg::TK_M1_B];
			pulses[15]    = trk_rise[gbeq_pkg::TK_M1_A];
		end

		result = '0;
		result[15:0]  = held;
		result[31:16] = pulses;
		result[34:32] = mode_new;
		result[35]    = link_new;
		result[36]    = link_new != link_q;
		result[38:37] = step_code[0];
		result[40:39] = step_code[1];
		result[42:41] = step_code[2];
		result[44:43] = step_code[3];
		result[46:45] = step_code[4];
		result[48:47] = step_code[5];
	end

	// State update on each processed tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= gbeq_pkg::MODE_ZERO;
			link_q        <= 1'b0;
			was_present_q <= 1'b0;
		end else if (advance) begin
			mode_q        <= mode_new;
			link_q        <= link_new;
			was_present_q <= present;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) out_data_q <= result;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

FILE: rtl/gbeq_tracker.sv
// One time-window debounce tracker with its held level and change timestamp.
module gbeq_tracker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           cur,
	input  logic [gbeq_pkg::TIME_W-1:0]    now,
	input  logic [gbeq_pkg::WIN_W-1:0]     window,
	output gbeq_pkg::trk_status_t          status
);

	logic                        level_q;
	logic [gbeq_pkg::TIME_W-1:0] last_q;
	logic [gbeq_pkg::TIME_W-1:0] elapsed;
	logic                        change;

	// Accept a new level once the window has passed (wrapping difference)
	always_comb begin
		elapsed      = now - last_q;
		change       = en && (cur != level_q) &&
			(elapsed >= {{(gbeq_pkg::TIME_W-gbeq_pkg::WIN_W){1'b0}}, window});
		status.rise  = change && cur;
		status.level = change ? cur : level_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= 1'b0;
			last_q  <= '0;
		end else if (change) begin
			level_q <= cur;
			last_q  <= now;
		end
	end

endmodule

FILE: rtl/gbeq_stepper.sv
// Press stepper: +1 on a press, -2 when a second press follows inside the window.
module gbeq_stepper (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           press,
	input  logic [gbeq_pkg::TIME_W-1:0]    now,
	input  logic [gbeq_pkg::WIN_W-1:0]     window,
	output logic [gbeq_pkg::STEP_W-1:0]    step
);

	logic [gbeq_pkg::TIME_W-1:0] prev_q;
	logic [gbeq_pkg::TIME_W-1:0] elapsed;
	logic                        dbl;

	// A stored time of zero means no first press pending
	always_comb begin
		elapsed = now - prev_q;
		dbl     = (prev_q != '0) &&
			(elapsed < {{(gbeq_pkg::TIME_W-gbeq_pkg::WIN_W){1'b0}}, window});
		if (!press) begin
			step = gbeq_pkg::STEP_NONE;
		end else if (dbl) begin
			step = gbeq_pkg::STEP_DOUBLE;
		end else begin
			step = gbeq_pkg::STEP_PLUS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (press) begin
			prev_q <= dbl ? '0 : now;
		end
	end

endmodule

FILE: rtl/gbeq_checker.sv
// Port-level checker for the qualifier core and its bind.
`include "assert_macros.svh"

module gbeq_port_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [gbeq_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	input logic                              pready
);

	// Result fields watched below
	logic                          out_stall;
	logic [gbeq_pkg::MODE_W-1:0]   mode_f;
	logic                          link_f;
	logic [31:0]                   mask_pulse_f;
	logic [11:0]                   step_f;

	assign out_stall    = m_axis_tvalid && !m_axis_tready;
	assign mode_f       = m_axis_tdata[34:32];
	assign link_f       = m_axis_tdata[35];
	assign mask_pulse_f = m_axis_tdata[31:0];
	assign step_f       = m_axis_tdata[48:37];

	// A stalled result stays offered
	`GBEQ_ASSERT(a_out_hold, clk, arst_n, out_stall |=> m_axis_tvalid)
	// A stalled result keeps its payload
	`GBEQ_ASSERT(a_out_stable, clk, arst_n, out_stall |=> $stable(m_axis_tdata))
	// Mode stays below five
	`GBEQ_ASSERT(a_mode_range, clk, arst_n, m_axis_tvalid |-> mode_f <= gbeq_pkg::MODE_LAST)
	// With the link off, mask, pulses and steps are all quiet
	`GBEQ_ASSERT(a_link_off_quiet, clk, arst_n, m_axis_tvalid && !link_f |-> !(|{mask_pulse_f, step_f}))
	// Configuration port never waits
	`GBEQ_ASSERT_ALWAYS(a_pready, clk, pready)

endmodule

bind gamepad_button_event_qualifier_core gbeq_port_checker u_gbeq_port_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.pready        (pready)
);
